@@ rtl/core/gbp_pkg.sv @@
// Shared types, constants and lookup functions for the G-code block parser.
`timescale 1ns / 1ps

package gbp_pkg;

    // word kinds
    localparam logic [3:0] KIND_NONE = 4'd0;
    localparam logic [3:0] KIND_SKIP = 4'd1;
    localparam logic [3:0] KIND_G    = 4'd2;
    localparam logic [3:0] KIND_M    = 4'd3;
    localparam logic [3:0] KIND_NUM  = 4'd4;

    // block codes
    localparam logic [2:0] CODE_G0  = 3'd0;
    localparam logic [2:0] CODE_G1  = 3'd1;
    localparam logic [2:0] CODE_G4  = 3'd2;
    localparam logic [2:0] CODE_G28 = 3'd3;
    localparam logic [2:0] CODE_M0  = 3'd4;
    localparam logic [2:0] CODE_M2  = 3'd5;
    localparam logic [2:0] CODE_M3  = 3'd6;
    localparam logic [2:0] CODE_M5  = 3'd7;

    // characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_M     = 8'h4D;

    // value slots
    localparam logic [2:0] SLOT_F = 3'd5;
    localparam logic [2:0] SLOT_P = 3'd6;
    localparam logic [2:0] SLOT_S = 3'd7;
    localparam int VALUE_SLOTS = 8;
    localparam int AXIS_COUNT  = 5;

    // pending flag layout
    localparam int PEND_W     = 13;
    localparam int PEND_CODE  = 0;
    localparam int PEND_COORD = 1;
    localparam int PEND_FEED  = 6;
    localparam int PEND_DWELL = 11;
    localparam int PEND_POWER = 12;

    // characters-after-letter counts
    localparam logic [2:0] CM_ONE_DIGIT   = 3'd1;
    localparam logic [2:0] CM_TWO_DIGITS  = 3'd2;
    localparam logic [2:0] CM_CODE_DIGITS = 3'd3;
    localparam logic [2:0] CM_MAX         = 3'd7;
    localparam int G28_NUMBER = 28;

    localparam int POW_W = 20;

    typedef struct packed {
        logic neg;
        logic point;
        logic stopped;
    } num_flags_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] kind;
        logic [2:0] code_match;
        logic       neg;
    } word_close_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
    } slot_hit_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] code;
    } code_hit_t;

    function automatic logic [POW_W-1:0] pow_ten(input logic [2:0] n);
        logic [POW_W-1:0] p;
        unique case (n)
            3'd0:    p = POW_W'(1);
            3'd1:    p = POW_W'(10);
            3'd2:    p = POW_W'(100);
            3'd3:    p = POW_W'(1000);
            3'd4:    p = POW_W'(10000);
            3'd5:    p = POW_W'(100000);
            3'd6:    p = POW_W'(1000000);
            default: p = POW_W'(1);
        endcase
        return p;
    endfunction

    function automatic slot_hit_t letter_slot(input logic [7:0] c);
        slot_hit_t r;
        r.hit = 1'b1;
        unique case (c)
            8'h58:   r.idx = 3'd0;  // X
            8'h59:   r.idx = 3'd1;  // Y
            8'h5A:   r.idx = 3'd2;  // Z
            8'h41:   r.idx = 3'd3;  // A
            8'h42:   r.idx = 3'd4;  // B
            8'h46:   r.idx = SLOT_F;
            8'h50:   r.idx = SLOT_P;
            8'h53:   r.idx = SLOT_S;
            default: begin
                r.hit = 1'b0;
                r.idx = 3'd0;
            end
        endcase
        return r;
    endfunction

    function automatic code_hit_t code_lookup(input logic is_m, input logic [3:0] d);
        code_hit_t r;
        r.hit  = 1'b1;
        r.code = CODE_G0;
        if (!is_m) begin
            unique case (d)
                4'd0:    r.code = CODE_G0;
                4'd1:    r.code = CODE_G1;
                4'd4:    r.code = CODE_G4;
                default: r.hit = 1'b0;
            endcase
        end else begin
            unique case (d)
                4'd0:    r.code = CODE_M0;
                4'd2:    r.code = CODE_M2;
                4'd3:    r.code = CODE_M3;
                4'd5:    r.code = CODE_M5;
                default: r.hit = 1'b0;
            endcase
        end
        return r;
    endfunction

endpackage

@@ rtl/core/gbp_word_parser.sv @@
// Per-character word tracking: word kind, code digits and decimal accumulate.
`timescale 1ns / 1ps

module gbp_word_parser import gbp_pkg::*; #(
    parameter int FRAC_DIGITS = 3,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   char_en,
    input  logic [7:0]             char_code,
    input  logic                   line_end,
    output word_close_t            close_info,
    output logic [VALUE_WIDTH-1:0] close_acc
);

    localparam int SUM_W = (VALUE_WIDTH + 4 > 26) ? VALUE_WIDTH + 4 : 26;
    localparam logic [POW_W-1:0] INT_SCALE = pow_ten(3'(FRAC_DIGITS));
    localparam logic [SUM_W-1:0] MAG_TOP   = SUM_W'(1) << (VALUE_WIDTH - 1);
    localparam logic [2:0]       FRAC_TOP  = 3'(FRAC_DIGITS);
    localparam logic [2:0]       FRAC_LAST = 3'(FRAC_DIGITS - 1);

    logic [3:0]             kind_reg, kind_next, kind_p;
    logic [2:0]             cm_reg, cm_p;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_p;
    logic [2:0]             fc_reg, fc_p;
    num_flags_t             flags_reg, flags_p;

    slot_hit_t              slot;
    logic                   is_sep, is_digit;
    logic [3:0]             digit;
    logic [SUM_W-1:0]       acc_ext, times_ten, int_sum, frac_sum;
    logic [SUM_W-1:0]       mag_limit, num_sum, num_sat;

    always_comb begin
        slot     = letter_slot(char_code);
        is_sep   = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
        is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
        digit    = char_code[3:0];

        acc_ext   = SUM_W'(acc_reg);
        times_ten = (acc_ext << 3) + (acc_ext << 1);
        int_sum   = times_ten + SUM_W'(digit) * SUM_W'(INT_SCALE);
        frac_sum  = acc_ext + SUM_W'(digit) * SUM_W'(pow_ten(FRAC_LAST - fc_reg));
        mag_limit = flags_reg.neg ? MAG_TOP : MAG_TOP - SUM_W'(1);
        num_sum   = flags_reg.point ? ((fc_reg < FRAC_TOP) ? frac_sum : acc_ext) : int_sum;
        num_sat   = (num_sum > mag_limit) ? mag_limit : num_sum;

        kind_p  = kind_reg;
        cm_p    = cm_reg;
        acc_p   = acc_reg;
        fc_p    = fc_reg;
        flags_p = flags_reg;

        if (!is_sep) begin
            if (kind_reg == KIND_NONE) begin
                cm_p    = '0;
                acc_p   = '0;
                fc_p    = '0;
                flags_p = '0;
                priority if (char_code == CH_G) begin
                    kind_p = KIND_G;
                end else if (char_code == CH_M) begin
                    kind_p = KIND_M;
                end else if (slot.hit) begin
                    kind_p = KIND_NUM + {1'b0, slot.idx};
                end else begin
                    kind_p = KIND_SKIP;
                end
            end else if (kind_reg == KIND_G || kind_reg == KIND_M) begin
                if (is_digit) begin
                    if (cm_reg < CM_CODE_DIGITS) begin
                        acc_p = VALUE_WIDTH'(times_ten + SUM_W'(digit));
                    end
                end else begin
                    kind_p = KIND_SKIP;
                end
                if (cm_reg != CM_MAX) begin
                    cm_p = cm_reg + 3'd1;
                end
            end else if (kind_reg >= KIND_NUM) begin
                if (cm_reg != CM_MAX) begin
                    cm_p = cm_reg + 3'd1;
                end
                if (!flags_reg.stopped) begin
                    priority if (cm_reg == '0 &&
                                 (char_code == CH_MINUS || char_code == CH_PLUS)) begin
                        flags_p.neg = (char_code == CH_MINUS);
                    end else if (char_code == CH_POINT && !flags_reg.point) begin
                        flags_p.point = 1'b1;
                    end else if (is_digit) begin
                        acc_p = VALUE_WIDTH'(num_sat);
                        if (flags_reg.point && fc_reg < FRAC_TOP) begin
                            fc_p = fc_reg + 3'd1;
                        end
                    end else begin
                        flags_p.stopped = 1'b1;
                    end
                end
            end
        end

        kind_next = (is_sep || line_end) ? KIND_NONE : kind_p;

        // separator closes the open word; line end closes the word just extended
        close_info.valid      = char_en && (is_sep || line_end) && (kind_p != KIND_NONE);
        close_info.kind       = kind_p;
        close_info.code_match = cm_p;
        close_info.neg        = flags_p.neg;
        close_acc             = acc_p;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg  <= KIND_NONE;
            cm_reg    <= '0;
            acc_reg   <= '0;
            fc_reg    <= '0;
            flags_reg <= '0;
        end else if (char_en) begin
            kind_reg  <= kind_next;
            cm_reg    <= cm_p;
            acc_reg   <= acc_p;
            fc_reg    <= fc_p;
            flags_reg <= flags_p;
        end
    end

endmodule

@@ rtl/core/gbp_block_hold.sv @@
// Held block: applies closed words to code, pending flags and values.
`timescale 1ns / 1ps

module gbp_block_hold import gbp_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  word_close_t            close_info,
    input  logic [VALUE_WIDTH-1:0] close_acc,
    input  logic                   line_accept,
    output logic [2:0]             res_code,
    output logic [PEND_W-1:0]      res_pending,
    output logic [VALUE_WIDTH-1:0] res_values [VALUE_SLOTS]
);

    logic [2:0]             code_reg, code_pre;
    logic [PEND_W-1:0]      pend_reg, pend_pre;
    logic [VALUE_WIDTH-1:0] values_reg [VALUE_SLOTS];
    logic [VALUE_WIDTH-1:0] values_pre [VALUE_SLOTS];

    logic                   is_code, is_m;
    code_hit_t              mapped;
    logic [2:0]             slot;
    logic [VALUE_WIDTH-1:0] signed_val;
    logic [AXIS_COUNT-1:0]  axes;

    always_comb begin
        code_pre   = code_reg;
        pend_pre   = pend_reg;
        values_pre = values_reg;

        is_code    = (close_info.kind == KIND_G) || (close_info.kind == KIND_M);
        is_m       = (close_info.kind == KIND_M);
        mapped     = code_lookup(is_m, close_acc[3:0]);
        slot       = 3'(close_info.kind - KIND_NUM);
        signed_val = close_info.neg ? (VALUE_WIDTH'(0) - close_acc) : close_acc;
        axes       = pend_reg[PEND_COORD +: AXIS_COUNT];

        if (close_info.valid) begin
            if (is_code) begin
                if (close_info.code_match == CM_ONE_DIGIT) begin
                    if (mapped.hit) begin
                        code_pre            = mapped.code;
                        pend_pre[PEND_CODE] = 1'b1;
                    end
                end else if (close_info.code_match == CM_TWO_DIGITS && !is_m &&
                             close_acc == VALUE_WIDTH'(G28_NUMBER)) begin
                    code_pre            = CODE_G28;
                    pend_pre[PEND_CODE] = 1'b1;
                end
            end else if (close_info.kind >= KIND_NUM) begin
                if (slot < SLOT_F) begin
                    values_pre[slot]            = signed_val;
                    pend_pre[PEND_COORD + slot] = 1'b1;
                end else if (slot == SLOT_F) begin
                    // feed only lands on axes already given a coordinate
                    if (axes != '0) begin
                        values_pre[SLOT_F] = signed_val;
                        pend_pre[PEND_FEED +: AXIS_COUNT] =
                            pend_reg[PEND_FEED +: AXIS_COUNT] | axes;
                    end
                end else if (slot == SLOT_P) begin
                    values_pre[SLOT_P]   = signed_val;
                    pend_pre[PEND_DWELL] = 1'b1;
                end else begin
                    values_pre[SLOT_S]   = signed_val;
                    pend_pre[PEND_POWER] = 1'b1;
                end
            end
        end

        res_code    = code_pre;
        res_pending = pend_pre;
        res_values  = values_pre;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || line_accept) begin
            code_reg <= '0;
            pend_reg <= '0;
            for (int i = 0; i < VALUE_SLOTS; i++) begin
                values_reg[i] <= '0;
            end
        end else begin
            code_reg   <= code_pre;
            pend_reg   <= pend_pre;
            values_reg <= values_pre;
        end
    end

endmodule

@@ rtl/core/gcode_block_parser.sv @@
// Top level of the G-code block parser: handshake, parser and result register.
`timescale 1ns / 1ps

// Takes one character word per cycle on the s_ channel and splits the line into
// whitespace-separated G, M, X, Y, Z, A, B, F, P and S words. The parsed block for
// a line appears on the m_ channel in the cycle after the character flagged with
// s_line_end is accepted, and sits in the result register until taken. Characters
// keep flowing while a block waits there; only a further line-ending character is
// held off until the waiting block is taken.
// The per-cycle path is set by the decimal accumulate: multiply by ten, add the
// scaled digit, saturate, then sign and store into the held block.
// Values are signed fixed point with FRAC_DIGITS fraction digits, VALUE_WIDTH wide.

module gcode_block_parser import gbp_pkg::*; #(
    parameter int FRAC_DIGITS = 3,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_char_code,
    input  logic                          s_line_end,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_block_code,
    output logic [PEND_W-1:0]             m_pending_flags,
    output logic signed [VALUE_WIDTH-1:0] m_x_target,
    output logic signed [VALUE_WIDTH-1:0] m_y_target,
    output logic signed [VALUE_WIDTH-1:0] m_z_target,
    output logic signed [VALUE_WIDTH-1:0] m_a_target,
    output logic signed [VALUE_WIDTH-1:0] m_b_target,
    output logic signed [VALUE_WIDTH-1:0] m_feed_rate,
    output logic signed [VALUE_WIDTH-1:0] m_dwell_time,
    output logic signed [VALUE_WIDTH-1:0] m_laser_power
);

    logic                   accept, line_accept;
    word_close_t            close_info;
    logic [VALUE_WIDTH-1:0] close_acc;

    logic [2:0]             res_code;
    logic [PEND_W-1:0]      res_pending;
    logic [VALUE_WIDTH-1:0] res_values [VALUE_SLOTS];

    logic                   m_valid_reg, m_valid_next;
    logic [2:0]             m_code_reg;
    logic [PEND_W-1:0]      m_pend_reg;
    logic [VALUE_WIDTH-1:0] m_values_reg [VALUE_SLOTS];

    assign s_ready     = !m_valid_reg || m_ready || !s_line_end;
    assign accept      = s_valid && s_ready;
    assign line_accept = accept && s_line_end;

    gbp_word_parser #(
        .FRAC_DIGITS (FRAC_DIGITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_word_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .char_en    (accept),
        .char_code  (s_char_code),
        .line_end   (s_line_end),
        .close_info (close_info),
        .close_acc  (close_acc)
    );

    gbp_block_hold #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_block_hold (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .close_info  (close_info),
        .close_acc   (close_acc),
        .line_accept (line_accept),
        .res_code    (res_code),
        .res_pending (res_pending),
        .res_values  (res_values)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (line_accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (line_accept) begin
            m_code_reg   <= res_code;
            m_pend_reg   <= res_pending;
            m_values_reg <= res_values;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_block_code    = m_code_reg;
    assign m_pending_flags = m_pend_reg;
    assign m_x_target      = m_values_reg[0];
    assign m_y_target      = m_values_reg[1];
    assign m_z_target      = m_values_reg[2];
    assign m_a_target      = m_values_reg[3];
    assign m_b_target      = m_values_reg[4];
    assign m_feed_rate     = m_values_reg[SLOT_F];
    assign m_dwell_time    = m_values_reg[SLOT_P];
    assign m_laser_power   = m_values_reg[SLOT_S];

    a_line_gives_block: assert property (@(posedge aclk) disable iff (!aresetn)
        line_accept |=> m_valid)
        else $error("line end accepted but no block presented");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && s_line_end) |-> !s_ready)
        else $error("line end accepted over an untaken block");

    a_feed_needs_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_pending_flags[PEND_FEED +: AXIS_COUNT] &
                      ~m_pending_flags[PEND_COORD +: AXIS_COUNT]) == '0))
        else $error("feed flagged on an axis without a coordinate");

    a_code_zero_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_pending_flags[PEND_CODE]) |-> (m_block_code == CODE_G0))
        else $error("block code set without code pending");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the G-code block parser: character stimulus, block prediction, checks.
`timescale 1ns / 1ps

module testbench;
    import gbp_pkg::*;

    localparam int VW        = 32;
    localparam int RUN_LIMIT = 200000;
    localparam int CHAR_GOAL = 1400;
    localparam logic [VALUE_SLOTS-1:0][7:0] VALUE_LETTERS = "SPFBAZYX";
    localparam logic [2:0][7:0] G_DIGITS = "410";
    localparam logic [3:0][7:0] M_DIGITS = "5320";

    typedef struct packed {
        logic [2:0]                   code;
        logic [PEND_W-1:0]            flags;
        logic [VALUE_SLOTS-1:0][VW-1:0] vals;   // X Y Z A B F P S, X lowest
    } block_t;

    class block_checker;
        localparam int FRAC  = 3;
        localparam int SCALE = 1000;

        logic [3:0]        kind;
        logic [2:0]        chars_seen;
        logic [63:0]       mag;
        int                frac_cnt;
        bit                neg, point, stopped;
        logic [2:0]        code_held;
        logic [PEND_W-1:0] pend;
        logic [63:0]       vals [VALUE_SLOTS];

        block_t            blocks_due[$];
        int                errors;
        int                blocks_checked;
        int                with_code;
        int                with_feed;

        function new();
            kind = KIND_NONE;
            chars_seen = '0;
            mag = '0;
            frac_cnt = 0;
            {neg, point, stopped} = '0;
            code_held = CODE_G0;
            pend = '0;
            foreach (vals[i]) vals[i] = '0;
            errors = 0;
            blocks_checked = 0;
            with_code = 0;
            with_feed = 0;
        endfunction

        function int outstanding();
            return blocks_due.size();
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 30)
                $display("%0t mismatch: %s", $realtime, msg);
        endtask

        function void close_word();
            logic [3:0]  k;
            logic [63:0] v;
            logic [2:0]  code;
            bit          hit;
            int          slot;
            k = kind;
            kind = KIND_NONE;
            hit = 1'b0;
            code = CODE_G0;
            if (k == KIND_G && chars_seen == CM_ONE_DIGIT) begin
                hit = 1'b1;
                case (mag % 10)
                    0: code = CODE_G0;
                    1: code = CODE_G1;
                    4: code = CODE_G4;
                    default: hit = 1'b0;
                endcase
            end else if (k == KIND_M && chars_seen == CM_ONE_DIGIT) begin
                hit = 1'b1;
                case (mag % 10)
                    0: code = CODE_M0;
                    2: code = CODE_M2;
                    3: code = CODE_M3;
                    5: code = CODE_M5;
                    default: hit = 1'b0;
                endcase
            end else if (k == KIND_G && chars_seen == CM_TWO_DIGITS && mag == G28_NUMBER) begin
                hit = 1'b1;
                code = CODE_G28;
            end
            if (hit) begin
                code_held = code;
                pend[PEND_CODE] = 1'b1;
            end
            if (k >= KIND_NUM) begin
                slot = int'(k) - int'(KIND_NUM);
                v = neg ? 64'd0 - mag : mag;
                if (slot < AXIS_COUNT) begin
                    vals[slot] = v;
                    pend[PEND_COORD + slot] = 1'b1;
                end else if (slot == SLOT_F) begin
                    // feed only binds to axes already on the line
                    if (pend[PEND_COORD +: AXIS_COUNT] != '0) begin
                        vals[SLOT_F] = v;
                        pend[PEND_FEED +: AXIS_COUNT] |= pend[PEND_COORD +: AXIS_COUNT];
                    end
                end else if (slot == SLOT_P) begin
                    vals[SLOT_P] = v;
                    pend[PEND_DWELL] = 1'b1;
                end else begin
                    vals[SLOT_S] = v;
                    pend[PEND_POWER] = 1'b1;
                end
            end
        endfunction

        function void take_char(logic [7:0] c, bit last);
            bit          first;
            logic [63:0] lim, d;
            block_t      want;
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                if (kind != KIND_NONE)
                    close_word();
            end else if (kind == KIND_NONE) begin
                chars_seen = '0;
                mag = '0;
                frac_cnt = 0;
                {neg, point, stopped} = '0;
                case (c)
                    CH_G:    kind = KIND_G;
                    CH_M:    kind = KIND_M;
                    "X":     kind = KIND_NUM;
                    "Y":     kind = KIND_NUM + 4'd1;
                    "Z":     kind = KIND_NUM + 4'd2;
                    "A":     kind = KIND_NUM + 4'd3;
                    "B":     kind = KIND_NUM + 4'd4;
                    "F":     kind = KIND_NUM + 4'(SLOT_F);
                    "P":     kind = KIND_NUM + 4'(SLOT_P);
                    "S":     kind = KIND_NUM + 4'(SLOT_S);
                    default: kind = KIND_SKIP;
                endcase
            end else if (kind == KIND_G || kind == KIND_M) begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    if (chars_seen < CM_CODE_DIGITS)
                        mag = mag * 10 + 64'(c - CH_ZERO);
                end else begin
                    kind = KIND_SKIP;
                end
                if (chars_seen != CM_MAX)
                    chars_seen++;
            end else if (kind >= KIND_NUM) begin
                first = (chars_seen == '0);
                if (chars_seen != CM_MAX)
                    chars_seen++;
                if (!stopped) begin
                    lim = neg ? (64'd1 << (VW - 1)) : (64'd1 << (VW - 1)) - 1;
                    if (first && (c == CH_MINUS || c == CH_PLUS)) begin
                        if (c == CH_MINUS)
                            neg = 1'b1;
                    end else if (c == CH_POINT && !point) begin
                        point = 1'b1;
                    end else if (c >= CH_ZERO && c <= CH_NINE) begin
                        d = 64'(c - CH_ZERO);
                        if (!point) begin
                            mag = mag * 10 + d * SCALE;
                        end else if (frac_cnt < FRAC) begin
                            mag += d * (64'd10 ** (FRAC - 1 - frac_cnt));
                            frac_cnt++;
                        end
                        if (mag > lim)
                            mag = lim;
                    end else begin
                        stopped = 1'b1;
                    end
                end
            end

            if (!last)
                return;
            if (kind != KIND_NONE)
                close_word();
            want.code  = pend[PEND_CODE] ? code_held : CODE_G0;
            want.flags = pend;
            for (int i = 0; i < AXIS_COUNT; i++)
                want.vals[i] = pend[PEND_COORD + i] ? vals[i][VW-1:0] : '0;
            want.vals[SLOT_F] = (pend[PEND_FEED +: AXIS_COUNT] != '0) ? vals[SLOT_F][VW-1:0] : '0;
            want.vals[SLOT_P] = pend[PEND_DWELL] ? vals[SLOT_P][VW-1:0] : '0;
            want.vals[SLOT_S] = pend[PEND_POWER] ? vals[SLOT_S][VW-1:0] : '0;
            blocks_due.push_back(want);
            code_held = CODE_G0;
            pend = '0;
            foreach (vals[i]) vals[i] = '0;
        endfunction

        task check_block(block_t got);
            block_t want;
            string  names [VALUE_SLOTS];
            names = '{"x_target", "y_target", "z_target", "a_target", "b_target",
                      "feed_rate", "dwell_time", "laser_power"};
            if (blocks_due.size() == 0) begin
                report_mismatch($sformatf("block with no line ended, flags %h", got.flags));
                return;
            end
            want = blocks_due.pop_front();
            if (got.code !== want.code)
                report_mismatch($sformatf("block %0d block_code %0d, want %0d",
                                          blocks_checked, got.code, want.code));
            if (got.flags !== want.flags)
                report_mismatch($sformatf("block %0d pending_flags %h, want %h",
                                          blocks_checked, got.flags, want.flags));
            for (int i = 0; i < VALUE_SLOTS; i++)
                if (got.vals[i] !== want.vals[i])
                    report_mismatch($sformatf("block %0d %s %0d, want %0d", blocks_checked,
                                              names[i], $signed(got.vals[i]),
                                              $signed(want.vals[i])));
            blocks_checked++;
            if (want.flags[PEND_CODE])
                with_code++;
            if (want.flags[PEND_FEED +: AXIS_COUNT] != '0)
                with_feed++;
        endtask
    endclass

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_char_code = '0;
    logic s_line_end = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [2:0] m_block_code;
    logic [PEND_W-1:0] m_pending_flags;
    logic signed [VW-1:0] m_x_target, m_y_target, m_z_target, m_a_target, m_b_target;
    logic signed [VW-1:0] m_feed_rate, m_dwell_time, m_laser_power;

    block_checker sb;
    logic [7:0]   line_buf[$];
    int           send_idle = 15;
    int           recv_idle = 69;
    int           chars_sent = 0;
    int           lines_sent = 0;
    int unsigned  cycle_count = 0;

    gcode_block_parser dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_code    (s_char_code),
        .s_line_end     (s_line_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_block_code   (m_block_code),
        .m_pending_flags(m_pending_flags),
        .m_x_target     (m_x_target),
        .m_y_target     (m_y_target),
        .m_z_target     (m_z_target),
        .m_a_target     (m_a_target),
        .m_b_target     (m_b_target),
        .m_feed_rate    (m_feed_rate),
        .m_dwell_time   (m_dwell_time),
        .m_laser_power  (m_laser_power)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d blocks outstanding", cycle_count,
                     sb.outstanding());
            $display("[gcode_block_parser] ERROR");
            $finish;
        end
    end

    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge aclk) begin
        block_t got;
        if (aresetn && m_valid && m_ready) begin
            got.code  = m_block_code;
            got.flags = m_pending_flags;
            got.vals  = {m_laser_power, m_dwell_time, m_feed_rate, m_b_target,
                         m_a_target, m_z_target, m_y_target, m_x_target};
            sb.check_block(got);
        end
    end

    task automatic send_char(input logic [7:0] c, input bit last);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_code <= c;
        s_line_end  <= last;
        do @(posedge aclk); while (!s_ready);
        sb.take_char(c, last);
        chars_sent++;
        if (last)
            lines_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.outstanding() != 0);
    endtask

    function automatic logic [7:0] random_non_sep();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR));
        return c;
    endfunction

    function automatic void add_digits(int n);
        repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
    endfunction

    function automatic void add_separators();
        repeat ($urandom_range(1, 2)) begin
            case ($urandom_range(9))
                0:       line_buf.push_back(CH_TAB);
                1:       line_buf.push_back(8'h0A);
                2:       line_buf.push_back(8'h0B);
                3:       line_buf.push_back(8'h0C);
                4:       line_buf.push_back(CH_CR);
                default: line_buf.push_back(CH_SPACE);
            endcase
        end
    endfunction

    function automatic logic [7:0] code_digit(logic is_m);
        if ($urandom_range(4) == 0)
            return CH_ZERO + 8'($urandom_range(9));
        return is_m ? M_DIGITS[$urandom_range(3)] : G_DIGITS[$urandom_range(2)];
    endfunction

    function automatic void add_code_word();
        logic is_m;
        int   form;
        is_m = 1'($urandom_range(1));
        form = $urandom_range(99);
        line_buf.push_back(is_m ? CH_M : CH_G);
        if (form < 60) begin
            line_buf.push_back(code_digit(is_m));
        end else if (form < 72) begin
            line_buf.push_back("2");
            line_buf.push_back("8");
        end else if (form < 80) begin
            add_digits(2);
        end else if (form < 86) begin
            line_buf.push_back(CH_ZERO);
            line_buf.push_back("2");
            line_buf.push_back("8");
        end else if (form < 93) begin
            line_buf.push_back(code_digit(is_m));
            line_buf.push_back(random_non_sep());
        end else if (form >= 96) begin
            add_digits($urandom_range(3, 9));
        end
    endfunction

    function automatic void add_value_word();
        int sign_pick, len_pick;
        sign_pick = $urandom_range(9);
        len_pick  = $urandom_range(19);
        line_buf.push_back(VALUE_LETTERS[$urandom_range(VALUE_SLOTS - 1)]);
        if (sign_pick < 3)
            line_buf.push_back(CH_MINUS);
        else if (sign_pick == 3)
            line_buf.push_back(CH_PLUS);
        if (len_pick >= 16)
            add_digits($urandom_range(7, 12));
        else if (len_pick >= 2)
            add_digits($urandom_range(1, 4));
        if ($urandom_range(2) != 0) begin
            line_buf.push_back(CH_POINT);
            add_digits($urandom_range(5));
        end
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
                0:       line_buf.push_back(CH_POINT);
                1:       line_buf.push_back(CH_MINUS);
                2:       line_buf.push_back(CH_PLUS);
                default: line_buf.push_back(random_non_sep());
            endcase
            add_digits($urandom_range(2));
        end
    endfunction

    function automatic void add_noise_word();
        // lower case letters mostly, so that g and m words are seen and ignored
        line_buf.push_back($urandom_range(1) ? 8'($urandom_range(8'h61, 8'h7A))
                                             : random_non_sep());
        repeat ($urandom_range(3)) line_buf.push_back(random_non_sep());
    endfunction

    task automatic send_random_line();
        int words, pick;
        line_buf.delete();
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(255)));
        end else begin
            words = $urandom_range(5);
            if ($urandom_range(4) == 0)
                add_separators();
            for (int w = 0; w < words; w++) begin
                if (w > 0)
                    add_separators();
                pick = $urandom_range(9);
                if (pick < 3)
                    add_code_word();
                else if (pick < 9)
                    add_value_word();
                else
                    add_noise_word();
            end
            if (words == 0 || $urandom_range(1) != 0)
                add_separators();
        end
        foreach (line_buf[i])
            send_char(line_buf[i], i == line_buf.size() - 1);
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // negative saturation ending on a digit, byte extremes as empty lines,
        // plus sign with a bare fraction ended by a tab
        send_text("G28 X-99999999");
        send_char(8'hFF, 1'b1);
        send_char(8'h00, 1'b1);
        send_text("M5 S+.5");
        send_char(CH_TAB, 1'b1);

        while (chars_sent < CHAR_GOAL / 3)
            send_random_line();
        wait_drained();

        send_idle = 69;
        recv_idle = 15;
        while (chars_sent < 2 * CHAR_GOAL / 3)
            send_random_line();

        send_idle = 0;
        recv_idle = 0;
        while (chars_sent < CHAR_GOAL)
            send_random_line();

        wait_drained();
        repeat (10) @(posedge aclk);
        $display("Sent %0d characters in %0d lines under three stall mixes, one full drain midway.",
                 chars_sent, lines_sent);
        $display("Checked %0d blocks: %0d carried a code, %0d a feed; %0d mismatches.",
                 sb.blocks_checked, sb.with_code, sb.with_feed, sb.errors);
        if (sb.errors == 0)
            $display("[gcode_block_parser] OK");
        else
            $display("[gcode_block_parser] ERROR");
        $finish;
    end

endmodule
